// File: rtl/core/obwp_pkg.sv
package obwp_pkg;

    localparam int RHYTHMS_DEF = 4;
    localparam int SAMPLES_DEF = 1024;
    localparam int HEADS_DEF   = 8;

    localparam int OP_W     = 2;
    localparam int RHYTHM_W = 2;
    localparam int INDEX_W  = 10;
    localparam int SAMPLE_W = 16;
    localparam int LENGTH_W = 11;
    localparam int SUM_W    = 19;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;

    localparam int SUM_MAX = 262143;
    localparam int SUM_MIN = -262144;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_LENGTH = 2'd1,
        OP_START  = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_NOWAVE = 2'd1,
        ST_NOFREE = 2'd2
    } t_status;

    typedef struct packed {
        t_op                        operation;
        logic [RHYTHM_W-1:0]        rhythm;
        logic [INDEX_W-1:0]         sample_index;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic [LENGTH_W-1:0]        waveform_length;
    } t_in_word;

    typedef struct packed {
        logic signed [SUM_W-1:0] potential_sum;
        t_status                 status;
        logic [COUNT_W-1:0]      active_heads;
    } t_out_word;

    typedef struct packed {
        logic clear;
        logic add;
    } t_acc_ctl;

endpackage

// File: rtl/core/obwp_if.sv
interface obwp_in_if import obwp_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface obwp_out_if import obwp_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/overlapping_beat_waveform_player_unit.sv
// Overlapping beat player for one lead. Every input word gives exactly one result word.
// Sample writes, length writes and beat starts pass from idle straight to the done state.
// A tick steps through every head: the head table memory is read once per head, and
// each read feeds one sample memory read whose data is added if that head is busy; a
// drain state waits for the last add to settle before the result is loaded. Heads are
// stored in a head memory (rhythm and position) with busy flags in flops; the sample
// store is RHYTHMS * SAMPLES words of uninitialized RAM, so there is no clearing pass
// after reset. A finished result waits in an output register while the next word is
// taken.
module overlapping_beat_waveform_player_unit import obwp_pkg::*; #(
    parameter int RHYTHMS = RHYTHMS_DEF,
    parameter int SAMPLES = SAMPLES_DEF,
    parameter int HEADS   = HEADS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    obwp_in_if.sink      i_in,
    obwp_out_if.source   o_out
);

    localparam int RW  = (RHYTHMS > 1) ? $clog2(RHYTHMS) : 1;
    localparam int XW  = (RW > RHYTHM_W) ? RW : RHYTHM_W;
    localparam int PW  = $clog2(SAMPLES);
    localparam int LW  = $clog2(SAMPLES + 1);
    localparam int HW  = (HEADS > 1) ? $clog2(HEADS) : 1;
    localparam int CW  = $clog2(HEADS + 1);
    localparam int SAW = $clog2(RHYTHMS * SAMPLES);
    localparam int HDW = RW + PW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state               r_state, n_state;
    logic [HW-1:0]        r_hidx, n_hidx;
    logic                 r_p1, n_p1;
    logic [HW-1:0]        r_p1h, n_p1h;
    logic                 r_p2, n_p2;
    logic                 r_p2v, n_p2v;
    logic [HEADS-1:0]     r_valid, n_valid;
    logic [LW-1:0]        r_len [RHYTHMS];
    logic [LW-1:0]        n_len [RHYTHMS];
    logic [CW-1:0]        r_count, n_count;
    t_status              r_status, n_status;
    logic                 r_out_valid, n_out_valid;
    t_out_word            r_out, n_out;

    t_in_word             w;
    logic                 in_acc;
    logic                 out_free;
    logic [XW-1:0]        rx;
    logic [RW-1:0]        ri;
    logic                 r_ok;

    logic                 free_any;
    logic [HW-1:0]        free_h;

    logic [HDW-1:0]       head_rdata;
    logic [RW-1:0]        s1_hr;
    logic [PW-1:0]        s1_pos;
    logic [LW-1:0]        s1_next;
    logic                 s1_last;
    logic                 s1_live;

    logic                 sw_we;
    logic [SAW-1:0]       sw_addr;
    logic [SAMPLE_W-1:0]  sw_data;
    logic                 sr_re;
    logic [SAW-1:0]       sr_addr;
    logic [SAMPLE_W-1:0]  sample_rdata;
    logic                 hw_we;
    logic [HW-1:0]        hw_addr;
    logic [HDW-1:0]       hw_data;
    logic                 hr_re;
    logic [HW-1:0]        hr_addr;

    t_acc_ctl             acc_ctl;
    logic signed [SUM_W-1:0] acc_sum;

    assign w        = i_in.data;
    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign rx       = XW'(w.rhythm);
    assign ri       = rx[RW-1:0];
    assign r_ok     = 32'(w.rhythm) < RHYTHMS;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        free_any = 1'b0;
        free_h   = '0;
        for (int h = HEADS - 1; h >= 0; h--) begin
            if (!r_valid[h]) begin
                free_any = 1'b1;
                free_h   = HW'(h);
            end
        end
    end

    assign s1_hr   = head_rdata[HDW-1:PW];
    assign s1_pos  = head_rdata[PW-1:0];
    assign s1_next = LW'(s1_pos) + LW'(1);
    assign s1_last = s1_next >= r_len[s1_hr];
    assign s1_live = r_valid[r_p1h];

    always_comb begin
        n_state     = r_state;
        n_hidx      = r_hidx;
        n_p1        = 1'b0;
        n_p1h       = r_p1h;
        n_p2        = r_p1;
        n_p2v       = r_p1 && s1_live;
        n_valid     = r_valid;
        n_len       = r_len;
        n_count     = r_count;
        n_status    = r_status;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;
        sw_we       = 1'b0;
        sw_addr     = '0;
        sw_data     = w.sample_value;
        sr_re       = 1'b0;
        sr_addr     = '0;
        hw_we       = 1'b0;
        hw_addr     = '0;
        hw_data     = '0;
        hr_re       = 1'b0;
        hr_addr     = r_hidx;
        acc_ctl     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    acc_ctl.clear = 1'b1;
                    n_status      = ST_OK;
                    n_state       = S_DONE;
                    unique case (w.operation)
                        OP_WRITE: begin
                            if (r_ok && 32'(w.sample_index) < SAMPLES) begin
                                sw_we   = 1'b1;
                                sw_addr = SAW'(32'(ri) * SAMPLES + 32'(w.sample_index));
                            end
                        end
                        OP_LENGTH: begin
                            if (r_ok) begin
                                n_len[ri] = (32'(w.waveform_length) > SAMPLES) ?
                                            LW'(SAMPLES) : LW'(w.waveform_length);
                            end
                        end
                        OP_START: begin
                            if (!r_ok || r_len[ri] == '0) begin
                                n_status = ST_NOWAVE;
                            end else if (!free_any) begin
                                n_status = ST_NOFREE;
                            end else begin
                                n_valid[free_h] = 1'b1;
                                n_count         = r_count + CW'(1);
                                hw_we           = 1'b1;
                                hw_addr         = free_h;
                                hw_data         = {ri, PW'(0)};
                            end
                        end
                        OP_TICK: begin
                            n_hidx  = '0;
                            n_state = S_TICK;
                        end
                    endcase
                end
            end
            S_TICK: begin
                hr_re = 1'b1;
                n_p1  = 1'b1;
                n_p1h = r_hidx;
                if (r_hidx == HW'(HEADS - 1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_hidx = r_hidx + HW'(1);
                end
            end
            S_DRAIN: begin
                if (!r_p1 && !r_p2) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.potential_sum = acc_sum;
                    n_out.status        = r_status;
                    n_out.active_heads  = COUNT_W'(r_count);
                    n_state             = S_IDLE;
                end
            end
        endcase

        // advance one head: fetch its sample, write back position, free at end
        if (r_p1) begin
            sr_re   = 1'b1;
            sr_addr = SAW'(32'(s1_hr) * SAMPLES + 32'(s1_pos));
            if (s1_live) begin
                hw_we   = 1'b1;
                hw_addr = r_p1h;
                hw_data = {s1_hr, s1_last ? PW'(0) : s1_next[PW-1:0]};
                if (s1_last) begin
                    n_valid[r_p1h] = 1'b0;
                    n_count        = r_count - CW'(1);
                end
            end
        end

        acc_ctl.add = r_p2 && r_p2v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            r_valid     <= '0;
            r_len       <= '{default: '0};
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_p1        <= n_p1;
            r_p2        <= n_p2;
            r_valid     <= n_valid;
            r_len       <= n_len;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_hidx      <= n_hidx;
            r_p1h       <= n_p1h;
            r_p2v       <= n_p2v;
            r_status    <= n_status;
            r_out       <= n_out;
        end
    end

    obwp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RHYTHMS * SAMPLES)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (sw_we),
        .i_waddr (sw_addr),
        .i_wdata (sw_data),
        .i_re    (sr_re),
        .i_raddr (sr_addr),
        .o_rdata (sample_rdata)
    );

    obwp_ram #(
        .WIDTH (HDW),
        .DEPTH (HEADS)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (hw_we),
        .i_waddr (hw_addr),
        .i_wdata (hw_data),
        .i_re    (hr_re),
        .i_raddr (hr_addr),
        .o_rdata (head_rdata)
    );

    obwp_accum #(
        .HEADS (HEADS)
    ) u_accum (
        .i_clk    (i_clk),
        .i_ctl    (acc_ctl),
        .i_sample (sample_rdata),
        .o_sum    (acc_sum)
    );

endmodule

// File: rtl/core/obwp_ram.sv
module obwp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: rtl/core/obwp_accum.sv
module obwp_accum import obwp_pkg::*; #(
    parameter int HEADS = HEADS_DEF
) (
    input  logic                        i_clk,
    input  t_acc_ctl                    i_ctl,
    input  logic signed [SAMPLE_W-1:0]  i_sample,
    output logic signed [SUM_W-1:0]     o_sum
);

    localparam int AW = (SAMPLE_W + 1 + $clog2(HEADS) > SUM_W) ?
                        SAMPLE_W + 1 + $clog2(HEADS) : SUM_W;
    localparam logic signed [AW-1:0] LIM_HI = AW'(SUM_MAX);
    localparam logic signed [AW-1:0] LIM_LO = AW'(SUM_MIN);

    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] n_acc;

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clear) begin
            n_acc = '0;
        end else if (i_ctl.add) begin
            n_acc = r_acc + AW'(i_sample);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    always_comb begin
        if (r_acc > LIM_HI) begin
            o_sum = LIM_HI[SUM_W-1:0];
        end else if (r_acc < LIM_LO) begin
            o_sum = LIM_LO[SUM_W-1:0];
        end else begin
            o_sum = r_acc[SUM_W-1:0];
        end
    end

endmodule

// File: rtl/core/obwp_checker.sv
module obwp_checker import obwp_pkg::*; #(
    parameter int HEADS = HEADS_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_word i_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result word dropped or changed while stalled");

    a_head_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> 32'(i_out_data.active_heads) <= HEADS)
        else $error("active head count above head count");

    a_status_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status != ST_OK |-> i_out_data.potential_sum == '0)
        else $error("failed start reports a nonzero sum");

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while previous word still in work");

endmodule

bind overlapping_beat_waveform_player_unit obwp_checker #(
    .HEADS (HEADS)
) u_obwp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
